### src/sac_lru_pkg.sv
// Package with the types, constants and helpers of the set-associative LRU tracker.
package sac_lru_pkg;

  // Cache geometry
  localparam int WAYS         = 4;
  localparam int MAX_SET_BITS = 6;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int CNT_W   = 32;
  localparam int AGE_W   = 4;
  localparam int RANK_W  = AGE_W + 1;
  localparam int SBITS_W = 3;
  localparam int BBITS_W = 5;
  localparam int SEFF_W  = 4;
  localparam int SHAMT_W = 6;

  // APB register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_SET_BITS   = 1'b0,
    REG_BLOCK_BITS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]       hits;
    logic             missed;
    logic             evicted;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } rsp_t;

  // Add a small increment to a counter, holding at all ones
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

### src/set_assoc_cache_lru_tracker.sv
// Set-associative cache hit/miss tracker with true-LRU replacement.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one trace transaction
// per item, an opcode (ignore, load, store, modify) and a byte address.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// item with its hits, miss and eviction flags and the saturating totals.
// APB port: register 0 (set_bits) at 0x0, register 1 (block_bits) at 0x4.
//
// Each item passes through a split step that computes set and tag and
// reads the set's tag and age rows, a scan of every way in turn through
// the single tag and age comparator, and a write-back step.
// The result is registered at write-back.
// in_stall_o is high while a transaction is in flight; a finished result
// waits in the output register, so a new item can be accepted while the
// receiver stalls, but its write-back waits until the register is free.
// Reset clears the valid bits, totals and configuration at once; there is
// no clearing pass, and tags and ages of invalid lines are never used.
module set_assoc_cache_lru_tracker
  import sac_lru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Access channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_data_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_data_o,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers
  logic [SBITS_W-1:0] set_bits_q;
  logic [BBITS_W-1:0] block_bits_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  // Sequencer
  state_e state_q, state_d;
  logic   accept, split_en, scan_en, commit, scan_last, out_free;

  // Transaction and address split
  logic [1:0]         opcode_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SEFF_W-1:0]  s_eff;
  logic [SHAMT_W-1:0] shamt;
  logic [ADDR_W-1:0]  blk_shift;
  logic [SET_W-1:0]   set_mask, set_d, set_q;
  logic [TAG_W-1:0]   tag_d, tag_q;

  // Line storage
  logic [NUM_SETS-1:0][WAYS-1:0]       valid_q;
  logic [WAYS-1:0][TAG_W-1:0]          tag_mem [NUM_SETS];
  logic [WAYS-1:0][AGE_W-1:0]          age_mem [NUM_SETS];
  logic [WAYS-1:0][TAG_W-1:0]          tag_row_q, tag_row_wr;
  logic [WAYS-1:0][AGE_W-1:0]          age_row_q, age_row_wr;
  logic [WAYS-1:0]                     vld_row_q;

  // Scan state
  logic [WAY_W-1:0] way_q;
  logic             hit_found_q, inv_found_q;
  logic [WAY_W-1:0] hit_way_q, inv_way_q, vic_way_q;
  logic [AGE_W-1:0] hit_age_q, vic_age_q;
  logic             cur_vld;
  logic [TAG_W-1:0] cur_tag;
  logic [AGE_W-1:0] cur_age;

  // Write-back
  logic              op_active, is_modify;
  logic [WAY_W-1:0]  chosen;
  logic [RANK_W-1:0] old_rank;
  logic [1:0]        hit_inc;
  logic              miss_now, evict_now;

  // Totals and result register
  logic [CNT_W-1:0] hit_total_q, miss_total_q, evict_total_q;
  logic [CNT_W-1:0] hit_total_d, miss_total_d, evict_total_d;
  logic             out_valid_q;
  rsp_t             out_q;

  // APB decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_SET_BITS:   prdata = {{(APB_DW-SBITS_W){1'b0}}, set_bits_q};
      REG_BLOCK_BITS: prdata = {{(APB_DW-BBITS_W){1'b0}}, block_bits_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SET_BITS:   set_bits_q   <= pwdata[SBITS_W-1:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[BBITS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer next state
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = (way_q == WAY_W'(WAYS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SPLIT;
      ST_SPLIT:  state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_UPDATE;
      ST_UPDATE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    split_en   = 1'b0;
    scan_en    = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SPLIT:  split_en   = 1'b1;
      ST_SCAN:   scan_en    = 1'b1;
      ST_UPDATE: commit     = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Split the address into set index and tag
  always_comb begin
    s_eff = (32'(set_bits_q) > MAX_SET_BITS) ? SEFF_W'(MAX_SET_BITS) : SEFF_W'(set_bits_q);
    shamt = SHAMT_W'(s_eff) + SHAMT_W'(block_bits_q);
    blk_shift = addr_q >> block_bits_q;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(s_eff));
    end
    set_d = blk_shift[SET_W-1:0] & set_mask;
    tag_d = (shamt >= SHAMT_W'(TAG_W)) ? '0 : TAG_W'(addr_q >> shamt);
  end

  // Current way as seen by the shared comparator
  assign cur_vld = vld_row_q[way_q];
  assign cur_tag = tag_row_q[way_q];
  assign cur_age = age_row_q[way_q];

  // Scan registers: capture the transaction, split, and walk the ways
  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= in_data_i.opcode;
      addr_q   <= in_data_i.address;
    end
    if (split_en) begin
      set_q       <= set_d;
      tag_q       <= tag_d;
      vld_row_q   <= valid_q[set_d];
      way_q       <= '0;
      hit_found_q <= 1'b0;
      inv_found_q <= 1'b0;
    end
    if (scan_en) begin
      way_q <= way_q + WAY_W'(1);
      if (cur_vld && (cur_tag == tag_q) && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_way_q   <= way_q;
        hit_age_q   <= cur_age;
      end
      if (!cur_vld && !inv_found_q) begin
        inv_found_q <= 1'b1;
        inv_way_q   <= way_q;
      end
      if ((way_q == '0) || (cur_age > vic_age_q)) begin
        vic_way_q <= way_q;
        vic_age_q <= cur_age;
      end
    end
  end

  // Choose the touched way and build the new rows
  always_comb begin
    op_active = (opcode_q != OP_IGNORE);
    is_modify = (opcode_q == OP_MODIFY);
    if (hit_found_q) begin
      chosen   = hit_way_q;
      old_rank = {1'b0, hit_age_q};
    end else if (inv_found_q) begin
      chosen   = inv_way_q;
      old_rank = RANK_W'(1 << AGE_W);
    end else begin
      chosen   = vic_way_q;
      old_rank = {1'b0, vic_age_q};
    end
    for (int i = 0; i < WAYS; i++) begin
      tag_row_wr[i] = tag_row_q[i];
      age_row_wr[i] = age_row_q[i];
      if (WAY_W'(i) == chosen) begin
        tag_row_wr[i] = tag_q;
        age_row_wr[i] = '0;
      end else if (vld_row_q[i] && ({1'b0, age_row_q[i]} < old_rank) &&
                   (age_row_q[i] != {AGE_W{1'b1}})) begin
        age_row_wr[i] = age_row_q[i] + AGE_W'(1);
      end
    end
    hit_inc   = op_active ? (2'(hit_found_q) + 2'(is_modify)) : 2'd0;
    miss_now  = op_active && !hit_found_q;
    evict_now = miss_now && !inv_found_q;
    hit_total_d   = sat_add(hit_total_q, hit_inc);
    miss_total_d  = sat_add(miss_total_q, 2'(miss_now));
    evict_total_d = sat_add(evict_total_q, 2'(evict_now));
  end

  // Tag and age memories: row read in the split cycle, row write on commit
  always_ff @(posedge clk_i) begin
    if (split_en) begin
      tag_row_q <= tag_mem[set_d];
      age_row_q <= age_mem[set_d];
    end
    if (commit && op_active) begin
      tag_mem[set_q] <= tag_row_wr;
      age_mem[set_q] <= age_row_wr;
    end
  end

  // Valid bits and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
    end else if (commit) begin
      if (op_active) begin
        valid_q[set_q][chosen] <= 1'b1;
      end
      hit_total_q   <= hit_total_d;
      miss_total_q  <= miss_total_d;
      evict_total_q <= evict_total_d;
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.hits            <= hit_inc;
      out_q.missed          <= miss_now;
      out_q.evicted         <= evict_now;
      out_q.total_hits      <= hit_total_d;
      out_q.total_misses    <= miss_total_d;
      out_q.total_evictions <= evict_total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted transaction blocks the input until its write-back
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after accepting a transaction");

  // An eviction is always a miss, and a miss never comes with two hits
  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.evicted) |-> out_data_o.missed)
    else $error("eviction reported without a miss");

  a_miss_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.missed) |-> (out_data_o.hits != 2'd2))
    else $error("miss reported with two hits");

  // Totals never decrease
  a_totals_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (hit_total_q >= $past(hit_total_q)) &&
               (miss_total_q >= $past(miss_total_q)) &&
               (evict_total_q >= $past(evict_total_q)))
    else $error("running total decreased");

  // The touched way is valid after write-back
  a_line_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_active) |=> valid_q[$past(set_q)][$past(chosen)])
    else $error("touched line not valid after write-back");

endmodule
